@@ hw/rtl/bfds_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bfds_pkg
// Shared constants for the box filter downscaler: size defaults, register
// indexes, reset values of the configuration registers and stream widths.
// ----------------------------------------------------------------------------
package bfds_pkg;

  localparam int DEF_MAX_OUT_COLS = 256;
  localparam int DEF_MAX_BLOCK    = 64;
  localparam int DEF_MAX_SRC_DIM  = 2048;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 2'd3;

  localparam logic [11:0] RST_SRC_WIDTH    = 12'd720;
  localparam logic [11:0] RST_SRC_HEIGHT   = 12'd1440;
  localparam logic [6:0]  RST_BLOCK_WIDTH  = 7'd18;
  localparam logic [6:0]  RST_BLOCK_HEIGHT = 7'd18;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

endpackage : bfds_pkg
`default_nettype wire

@@ hw/rtl/box_filter_downscaler_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_downscaler_unit
// Box filter downscaler: averages RGB source pixels over blocks of a
// configurable size and emits one averaged pixel per block.
//
// Source pixels enter in raster order on the in_ stream, one item per pixel.
// Each output column owns one entry of a line store that holds the running
// red, green and blue sums of its block. A pixel is read from the store in
// the cycle it is accepted and the updated sums are written back in the next
// cycle; back-to-back pixels of the same block use a forwarded copy of the
// last write. When the bottom-right pixel of a block has been summed, a
// restoring divider produces the three averages, one quotient bit per cycle.
// Pixels that do not finish a block are taken back to back. A pixel that
// finishes one stalls the input for the divider: the averaged item goes
// from the divider through the hold state into the output register on out_,
// and the next pixel is taken once the unit is back in its run state.
// A finished item waits in the output register while out_tready is low;
// pixels that do not finish a block keep flowing, but the next finished
// block holds the input until the output register is free.
// Reset restores the register defaults and clears all position counters.
// Users must write cfg_ registers only while the stream is idle; unenforced.
// ----------------------------------------------------------------------------
module box_filter_downscaler_unit #(
  parameter int MAX_OUT_COLS = bfds_pkg::DEF_MAX_OUT_COLS,
  parameter int MAX_BLOCK    = bfds_pkg::DEF_MAX_BLOCK,
  parameter int MAX_SRC_DIM  = bfds_pkg::DEF_MAX_SRC_DIM
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [bfds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bfds_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // pix_red[7:0], pix_green[15:8], pix_blue[23:16]
  input  wire logic [bfds_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // out_col[7:0], out_row[18:8], avg_red[26:19], avg_green[34:27],
  // avg_blue[42:35], zero fill[47:43]
  output logic [bfds_pkg::OUT_DATA_W-1:0]      out_tdata,
  // frame_end
  output logic                                 out_tlast
);
  import bfds_pkg::*;

  localparam int DIM_W  = $clog2(MAX_SRC_DIM);
  localparam int EW     = $clog2(MAX_SRC_DIM + 1);
  localparam int CB_W   = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int BEW    = $clog2(MAX_BLOCK + 1);
  localparam int CNT_W  = 2 * BEW;
  localparam int SUM_W  = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
  localparam int AW     = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
  localparam int BC_W0  = (DIM_W > AW) ? DIM_W : AW;
  localparam int BC_W   = (BC_W0 > 8) ? BC_W0 : 8;
  localparam int BR_W   = (DIM_W > 11) ? DIM_W : 11;
  localparam int ITW    = $clog2(SUM_W);
  localparam int MEM_W  = 3 * SUM_W;

  typedef enum logic [1:0] {ST_RUN, ST_DIV, ST_HOLD} state_t;

  state_t state_r;

  logic [11:0] src_width_r, src_height_r;
  logic [6:0]  block_width_r, block_height_r;

  logic [DIM_W-1:0] src_col_r, src_row_r;
  logic [CB_W-1:0]  cib_r, rib_r;
  logic [BC_W-1:0]  blk_col_r;
  logic [BR_W-1:0]  blk_row_r;

  logic [MEM_W-1:0] mem [MAX_OUT_COLS];
  logic [MEM_W-1:0] rd_data_r;

  logic             s1_valid_r;
  logic             s1_write_r, s1_start_r, s1_emit_r, s1_fend_r;
  logic [AW-1:0]    s1_addr_r;
  logic [7:0]       s1_pix_r [3];
  logic [CNT_W-1:0] s1_cnt_r;
  logic [7:0]       s1_col_r;
  logic [10:0]      s1_row_r;

  logic             lw_valid_r;
  logic [AW-1:0]    lw_addr_r;
  logic [MEM_W-1:0] lw_data_r;

  logic [SUM_W-1:0] dvd_r [3];
  logic [CNT_W-1:0] rem_r [3];
  logic [CNT_W-1:0] divisor_r;
  logic [ITW-1:0]   iter_r;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tlast_r;

  logic [EW-1:0]    w_eff, h_eff;
  logic [BEW-1:0]   bw_eff, bh_eff;
  logic             last_col, last_row, col_end, row_end, in_range, in_acc;
  logic [BEW-1:0]   cib_p1, rib_p1;
  logic [CNT_W-1:0] cnt;
  logic [MEM_W-1:0] base, wr_data;
  logic [SUM_W-1:0] dvd_nxt [3];
  logic [CNT_W-1:0] rem_nxt [3];
  logic [CNT_W:0]   rem_sh  [3];

  always_comb begin
    if (src_width_r == '0) begin
      w_eff = EW'(1);
    end else if (32'(src_width_r) > MAX_SRC_DIM) begin
      w_eff = EW'(MAX_SRC_DIM);
    end else begin
      w_eff = EW'(src_width_r);
    end
    if (src_height_r == '0) begin
      h_eff = EW'(1);
    end else if (32'(src_height_r) > MAX_SRC_DIM) begin
      h_eff = EW'(MAX_SRC_DIM);
    end else begin
      h_eff = EW'(src_height_r);
    end
    if (block_width_r == '0) begin
      bw_eff = BEW'(1);
    end else if (32'(block_width_r) > MAX_BLOCK) begin
      bw_eff = BEW'(MAX_BLOCK);
    end else begin
      bw_eff = BEW'(block_width_r);
    end
    if (block_height_r == '0) begin
      bh_eff = BEW'(1);
    end else if (32'(block_height_r) > MAX_BLOCK) begin
      bh_eff = BEW'(MAX_BLOCK);
    end else begin
      bh_eff = BEW'(block_height_r);
    end
  end

  assign cib_p1   = BEW'(cib_r) + BEW'(1);
  assign rib_p1   = BEW'(rib_r) + BEW'(1);
  assign last_col = (EW'(src_col_r) + EW'(1)) >= w_eff;
  assign last_row = (EW'(src_row_r) + EW'(1)) >= h_eff;
  assign col_end  = last_col || (cib_p1 >= bw_eff);
  assign row_end  = last_row || (rib_p1 >= bh_eff);
  assign in_range = 32'(blk_col_r) < MAX_OUT_COLS;
  assign cnt      = CNT_W'(cib_p1) * CNT_W'(rib_p1);

  assign in_tready = (state_r == ST_RUN) && !(s1_valid_r && s1_emit_r);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (lw_valid_r && (lw_addr_r == s1_addr_r)) begin
      base = lw_data_r;
    end else begin
      base = rd_data_r;
    end
    if (s1_start_r) begin
      base = '0;
    end
    for (int c = 0; c < 3; c++) begin
      wr_data[c*SUM_W +: SUM_W] = base[c*SUM_W +: SUM_W] + SUM_W'(s1_pix_r[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem_sh[c] = {rem_r[c], dvd_r[c][SUM_W-1]};
      if (rem_sh[c] >= {1'b0, divisor_r}) begin
        rem_nxt[c] = CNT_W'(rem_sh[c] - {1'b0, divisor_r});
        dvd_nxt[c] = {dvd_r[c][SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[c] = CNT_W'(rem_sh[c]);
        dvd_nxt[c] = {dvd_r[c][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= mem[blk_col_r[AW-1:0]];
    end
    if (s1_valid_r && s1_write_r) begin
      mem[s1_addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_RUN;
      src_width_r    <= RST_SRC_WIDTH;
      src_height_r   <= RST_SRC_HEIGHT;
      block_width_r  <= RST_BLOCK_WIDTH;
      block_height_r <= RST_BLOCK_HEIGHT;
      src_col_r      <= '0;
      src_row_r      <= '0;
      cib_r          <= '0;
      rib_r          <= '0;
      blk_col_r      <= '0;
      blk_row_r      <= '0;
      s1_valid_r     <= 1'b0;
      lw_valid_r     <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_WIDTH:    src_width_r    <= cfg_wdata;
          CFG_SRC_HEIGHT:   src_height_r   <= cfg_wdata;
          CFG_BLOCK_WIDTH:  block_width_r  <= cfg_wdata[6:0];
          CFG_BLOCK_HEIGHT: block_height_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end

      if (out_tvalid_r && out_tready && (state_r != ST_HOLD)) begin
        out_tvalid_r <= 1'b0;
      end

      s1_valid_r <= in_acc;
      if (in_acc) begin
        s1_write_r <= in_range;
        s1_start_r <= (cib_r == '0) && (rib_r == '0);
        s1_emit_r  <= in_range && col_end && row_end;
        s1_fend_r  <= last_col && last_row;
        s1_addr_r  <= blk_col_r[AW-1:0];
        s1_pix_r[0] <= in_tdata[7:0];
        s1_pix_r[1] <= in_tdata[15:8];
        s1_pix_r[2] <= in_tdata[23:16];
        s1_cnt_r   <= cnt;
        s1_col_r   <= blk_col_r[7:0];
        s1_row_r   <= blk_row_r[10:0];
        if (last_col) begin
          src_col_r <= '0;
          cib_r     <= '0;
          blk_col_r <= '0;
          if (last_row) begin
            src_row_r <= '0;
            rib_r     <= '0;
            blk_row_r <= '0;
          end else begin
            src_row_r <= src_row_r + DIM_W'(1);
            if (row_end) begin
              rib_r     <= '0;
              blk_row_r <= blk_row_r + BR_W'(1);
            end else begin
              rib_r <= rib_r + CB_W'(1);
            end
          end
        end else begin
          src_col_r <= src_col_r + DIM_W'(1);
          if (col_end) begin
            cib_r     <= '0;
            blk_col_r <= blk_col_r + BC_W'(1);
          end else begin
            cib_r <= cib_r + CB_W'(1);
          end
        end
      end

      if (s1_valid_r && s1_write_r) begin
        lw_valid_r <= 1'b1;
        lw_addr_r  <= s1_addr_r;
        lw_data_r  <= wr_data;
      end

      case (state_r)
        ST_RUN: begin
          if (s1_valid_r && s1_emit_r) begin
            for (int c = 0; c < 3; c++) begin
              dvd_r[c] <= wr_data[c*SUM_W +: SUM_W];
              rem_r[c] <= '0;
            end
            divisor_r <= s1_cnt_r;
            iter_r    <= ITW'(SUM_W - 1);
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          for (int c = 0; c < 3; c++) begin
            dvd_r[c] <= dvd_nxt[c];
            rem_r[c] <= rem_nxt[c];
          end
          iter_r <= iter_r - ITW'(1);
          if (iter_r == '0) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {5'd0, dvd_r[2][7:0], dvd_r[1][7:0], dvd_r[0][7:0],
                             s1_row_r, s1_col_r};
            out_tlast_r  <= s1_fend_r;
            state_r      <= ST_RUN;
          end
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  a_emit_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && s1_valid_r && s1_emit_r) |=> (state_r == ST_DIV))
    else $error("finished block did not start the divider");

  a_no_pixel_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> !s1_valid_r)
    else $error("pixel in flight while the divider runs");

  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_HOLD))
    else $error("output item loaded outside the hold state");

  a_block_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cib_r) < MAX_BLOCK) && (32'(rib_r) < MAX_BLOCK))
    else $error("position inside block ran past the largest block");

endmodule : box_filter_downscaler_unit
`default_nettype wire
